// ----- rtl/buddy_block_allocator_defines.svh -----
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MIN_ORDER_D    = 5;
  localparam int MAX_ORDER_D    = 16;
  localparam int POOL_BYTES_D   = 65536;
  localparam int HEADER_BYTES_D = 24;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOBLOCK = 2'd1;
  localparam logic [1:0] ST_DOUBLE  = 2'd2;
  localparam logic [1:0] ST_BADPTR  = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

endpackage

// ----- rtl/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator whose slot headers and free-list links live in one RAM.
// ----------------------------------------------------------------------------
// channel  | signals                                   | handshake
// command  | func, request_size, user_offset           | start & !busy
// result   | status, granted_offset, used_bytes,       | done, one cycle
//          | block_count, free_bytes                   |
// After reset a clearing pass writes every slot with busy high,
// then the carving pass pushes the initial blocks.
// At most one RAM access per cycle. A remove clears a slot's links and fixes
// its neighbours; a push makes the slot the new head. Allocate: size and list
// searches step an order at a time, each split removes a block and pushes its
// halves. Free: each merge removes both buddies and pushes the merged block.
// The result strobe is not stallable; the next command may start right after.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int MIN_ORDER_P  = bba_pkg::MIN_ORDER_D,
  parameter int MAX_ORDER_P  = bba_pkg::MAX_ORDER_D,
  parameter int POOL_BYTES   = bba_pkg::POOL_BYTES_D,
  parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [15:0] request_size,
  input  logic [15:0] user_offset,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] granted_offset,
  output logic [16:0] used_bytes,
  output logic [11:0] block_count,
  output logic [16:0] free_bytes
);
  import bba_pkg::*;
  `include "buddy_block_allocator_defines.svh"

  localparam int SLOTS   = POOL_BYTES >> MIN_ORDER_P;
  localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW      = SW + 1;               // link width incl. null
  localparam int NORD    = MAX_ORDER_P - MIN_ORDER_P + 1;
  localparam int LIW     = (NORD > 1) ? $clog2(NORD) : 1;
  localparam int OW      = 5;
  localparam int EW      = 1 + OW + 2 * LW;      // free, order, next, prev
  localparam int UW      = 40;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  // RAM entry layout
  typedef struct packed {
    logic          fr;
    logic [OW-1:0] ord;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } entry_t;

  // sequencer states
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_CARVE  = 5'd1;
  localparam logic [4:0] S_IDLE   = 5'd2;
  localparam logic [4:0] S_AFIND  = 5'd3;
  localparam logic [4:0] S_SPLIT  = 5'd4;
  localparam logic [4:0] S_TAKE   = 5'd5;
  localparam logic [4:0] S_FRD    = 5'd6;
  localparam logic [4:0] S_FCHK   = 5'd7;
  localparam logic [4:0] S_MRD    = 5'd8;
  localparam logic [4:0] S_MCHK   = 5'd9;
  localparam logic [4:0] S_DONE   = 5'd10;
  // micro ops: push / remove
  localparam logic [4:0] S_PU_RD  = 5'd11;
  localparam logic [4:0] S_PU_WR  = 5'd12;
  localparam logic [4:0] S_PU_HW  = 5'd13;
  localparam logic [4:0] S_RM_RD  = 5'd14;
  localparam logic [4:0] S_RM_W0  = 5'd15;
  localparam logic [4:0] S_RM_PR  = 5'd16;
  localparam logic [4:0] S_RM_PW  = 5'd17;
  localparam logic [4:0] S_RM_NR  = 5'd18;
  localparam logic [4:0] S_RM_NW  = 5'd19;
  localparam logic [4:0] S_WAIT   = 5'd20;
  localparam logic [4:0] S_RM_NQ  = 5'd21;

  // after-op continuation codes
  localparam logic [3:0] K_CARVE  = 4'd0;
  localparam logic [3:0] K_SP1    = 4'd1;
  localparam logic [3:0] K_SP2    = 4'd2;
  localparam logic [3:0] K_SP3    = 4'd3;
  localparam logic [3:0] K_TAKE   = 4'd4;
  localparam logic [3:0] K_FPUSH  = 4'd5;
  localparam logic [3:0] K_M1     = 4'd6;
  localparam logic [3:0] K_M2     = 4'd7;
  localparam logic [3:0] K_M3     = 4'd8;

  logic [4:0]  state;
  logic [3:0]  kont;
  logic [4:0]  wait_ret;

  logic          we;
  logic [SW-1:0] addr;
  entry_t        wdata, rdata;

  bba_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [LW-1:0] head [NORD];

  logic [SW-1:0] clr_idx;
  logic [UW-1:0] c_off, c_rem;
  logic [OW-1:0] c_ord;

  logic [15:0]   op_size;
  logic [15:0]   op_uoff;
  logic [OW-1:0] need_ord, k_ord;
  logic [SW-1:0] cur, bud;
  logic [OW-1:0] cur_ord;

  // micro op operands
  logic [SW-1:0] u_slot;
  logic [OW-1:0] u_ord;
  logic [LW-1:0] u_p, u_n;

  logic [16:0]   used_total;
  logic [11:0]   alloc_total;

  logic [1:0]    res_st;
  logic [15:0]   res_off;

  logic [UW-1:0] need_w, boff_w;
  logic [SW-1:0] s_idx;

  assign need_w = UW'(op_size) + UW'(HEADER_BYTES);
  assign boff_w = UW'(op_uoff) - UW'(HEADER_BYTES);
  assign s_idx  = SW'(boff_w >> MIN_ORDER_P);

  function automatic logic [UW-1:0] pw(input logic [OW-1:0] o);
    return UW'(1) << o;
  endfunction

  // free list index of an order
  function automatic logic [LIW-1:0] lidx(input logic [OW-1:0] o);
    return LIW'(o - OW'(MIN_ORDER_P));
  endfunction

  assign busy = (state != S_IDLE);
  assign used_bytes  = used_total;
  assign block_count = alloc_total;
  assign free_bytes  = 17'(UW'(POOL_BYTES) - UW'(used_total));

  always_ff @(posedge clk) begin
    if (rst) begin
      we          <= 1'b0;
      done        <= 1'b0;
      state       <= S_CLR;
      clr_idx     <= '0;
      used_total  <= '0;
      alloc_total <= '0;
      c_off       <= '0;
      c_rem       <= UW'(POOL_BYTES);
      c_ord       <= OW'(MAX_ORDER_P);
      for (int i = 0; i < NORD; i++) head[i] <= NIL;
    end else begin
      // states that issue a RAM write
      we   <= (state == S_CLR) || (state == S_PU_RD) || (state == S_TAKE)
              || (state == S_RM_W0) || (state == S_RM_NR) || (state == S_RM_PR);
      done <= (state == S_DONE);
      unique case (state)
        S_CLR: begin
          addr  <= clr_idx;
          wdata <= '{fr: 1'b0, ord: '0, nxt: NIL, prv: NIL};
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SW'(SLOTS - 1)) state <= S_CARVE;
        end
        S_CARVE: begin
          if (c_rem < pw(OW'(MIN_ORDER_P))) begin
            state <= S_IDLE;
          end else if (pw(c_ord) > c_rem && c_ord > OW'(MIN_ORDER_P)) begin
            c_ord <= c_ord - 1'b1;
          end else begin
            u_slot <= SW'(c_off >> MIN_ORDER_P);
            u_ord  <= c_ord;
            c_off  <= c_off + pw(c_ord);
            c_rem  <= c_rem - pw(c_ord);
            kont   <= K_CARVE;
            state  <= S_PU_RD;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_size <= request_size;
            op_uoff <= user_offset;
            need_ord <= OW'(MIN_ORDER_P);
            res_off <= '0;
            if (func == FUNC_ALLOC) state <= S_AFIND;
            else state <= S_FRD;
          end
        end
        S_AFIND: begin
          // find smallest fitting order, then first nonempty list
          if (op_size == '0) begin
            res_st <= ST_NOBLOCK; state <= S_DONE;
          end else if (pw(need_ord) < need_w && need_ord < OW'(MAX_ORDER_P)) begin
            need_ord <= need_ord + 1'b1;
          end else if (pw(need_ord) < need_w) begin
            res_st <= ST_NOBLOCK; state <= S_DONE;
          end else begin
            k_ord <= need_ord;
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (k_ord > OW'(MAX_ORDER_P)) begin
            res_st <= ST_NOBLOCK; state <= S_DONE;
          end else if (head[lidx(k_ord)] == NIL) begin
            k_ord <= k_ord + 1'b1;
          end else if (k_ord == need_ord) begin
            u_slot <= SW'(head[lidx(k_ord)]);
            cur    <= SW'(head[lidx(k_ord)]);
            u_ord  <= k_ord;
            kont   <= K_TAKE;
            state  <= S_RM_RD;
          end else begin
            u_slot <= SW'(head[lidx(k_ord)]);
            cur    <= SW'(head[lidx(k_ord)]);
            u_ord  <= k_ord;
            kont   <= K_SP1;
            state  <= S_RM_RD;
          end
        end
        S_TAKE: begin
          addr  <= cur;
          wdata <= '{fr: 1'b0, ord: need_ord, nxt: NIL, prv: NIL};
          alloc_total <= alloc_total + 1'b1;
          used_total  <= 17'(UW'(used_total) + pw(need_ord) - UW'(HEADER_BYTES));
          res_off <= 16'((UW'(cur) << MIN_ORDER_P) + UW'(HEADER_BYTES));
          res_st  <= ST_OK;
          state   <= S_DONE;
        end
        S_FRD: begin
          if (UW'(op_uoff) < UW'(HEADER_BYTES) || boff_w[MIN_ORDER_P-1:0] != '0
              || (boff_w >> MIN_ORDER_P) >= UW'(SLOTS)) begin
            res_st <= ST_BADPTR; state <= S_DONE;
          end else begin
            addr <= s_idx; wait_ret <= S_FCHK; state <= S_WAIT;
          end
        end
        S_FCHK: begin
          if (rdata.fr) begin
            res_st <= ST_DOUBLE; state <= S_DONE;
          end else if (rdata.ord < OW'(MIN_ORDER_P) || rdata.ord > OW'(MAX_ORDER_P)
                       || (boff_w & (pw(rdata.ord) - 1'b1)) != '0
                       || boff_w + pw(rdata.ord) > UW'(POOL_BYTES)) begin
            res_st <= ST_BADPTR; state <= S_DONE;
          end else begin
            alloc_total <= alloc_total - 1'b1;
            used_total  <= 17'(UW'(used_total) - (pw(rdata.ord) - UW'(HEADER_BYTES)));
            cur <= s_idx; cur_ord <= rdata.ord;
            u_slot <= s_idx; u_ord <= rdata.ord;
            kont <= K_FPUSH; state <= S_PU_RD;
          end
        end
        S_MRD: begin
          if (cur_ord >= OW'(MAX_ORDER_P)) begin
            res_st <= ST_OK; state <= S_DONE;
          end else begin
            bud <= cur ^ SW'(UW'(1) << (cur_ord - OW'(MIN_ORDER_P)));
            if ((UW'(cur) ^ (UW'(1) << (cur_ord - OW'(MIN_ORDER_P)))) >= UW'(SLOTS)) begin
              res_st <= ST_OK; state <= S_DONE;
            end else begin
              addr <= cur ^ SW'(UW'(1) << (cur_ord - OW'(MIN_ORDER_P)));
              wait_ret <= S_MCHK; state <= S_WAIT;
            end
          end
        end
        S_MCHK: begin
          if (!rdata.fr || rdata.ord != cur_ord) begin
            res_st <= ST_OK; state <= S_DONE;
          end else begin
            u_slot <= cur; u_ord <= cur_ord; kont <= K_M1; state <= S_RM_RD;
          end
        end
        S_DONE: begin
          status <= res_st;
          granted_offset <= res_off;
          state <= S_IDLE;
        end
        S_WAIT: state <= wait_ret;
        // push u_slot onto list u_ord
        S_PU_RD: begin
          u_n <= head[lidx(u_ord)];
          addr <= u_slot;
          wdata <= '{fr: 1'b1, ord: u_ord, nxt: head[lidx(u_ord)], prv: NIL};
          head[lidx(u_ord)] <= LW'(u_slot);
          state <= S_PU_WR;
        end
        S_PU_WR: begin
          if (u_n != NIL) begin
            addr <= SW'(u_n); state <= S_PU_HW;
          end else state <= S_RM_NW;   // reuse as continuation dispatcher
        end
        S_PU_HW: begin
          // wait read of old head, then write its prev
          state <= S_RM_PR;
        end
        S_RM_RD: begin
          addr <= u_slot; wait_ret <= S_RM_W0; state <= S_WAIT;
        end
        S_RM_W0: begin
          u_p <= rdata.prv; u_n <= rdata.nxt;
          addr <= u_slot;
          wdata <= '{fr: rdata.fr, ord: rdata.ord, nxt: NIL, prv: NIL};
          if (rdata.prv == NIL) head[lidx(u_ord)] <= rdata.nxt;
          state <= S_RM_PW;
        end
        S_RM_PW: begin
          if (u_p != NIL) begin
            addr <= SW'(u_p); wait_ret <= S_RM_NR; state <= S_WAIT;
          end else state <= S_RM_NQ;
        end
        S_RM_NR: begin
          // rdata holds entry u_p; point it past the removed slot
          addr <= SW'(u_p);
          wdata <= '{fr: rdata.fr, ord: rdata.ord, nxt: u_n, prv: rdata.prv};
          state <= S_RM_NQ;
        end
        S_RM_NQ: begin
          if (u_n != NIL) begin
            addr <= SW'(u_n); wait_ret <= S_RM_PR; state <= S_WAIT;
          end else state <= S_RM_NW;
        end
        S_RM_PR: begin
          // rdata holds entry u_n; set its prev to u_p (push uses u_slot)
          addr <= SW'(u_n);
          wdata <= '{fr: rdata.fr, ord: rdata.ord, nxt: rdata.nxt,
                     prv: (kont == K_CARVE || kont == K_SP2 || kont == K_SP3
                           || kont == K_FPUSH || kont == K_M3) ? LW'(u_slot) : u_p};
          u_n <= NIL;
          state <= S_RM_NW;
        end
        S_RM_NW: begin
          // continuation dispatch
          unique case (kont)
            K_CARVE: state <= S_CARVE;
            K_SP1: begin
              u_ord <= k_ord - 1'b1; u_slot <= cur; kont <= K_SP2; state <= S_PU_RD;
            end
            K_SP2: begin
              u_slot <= cur + SW'(UW'(1) << (k_ord - 1'b1 - OW'(MIN_ORDER_P)));
              u_ord <= k_ord - 1'b1; kont <= K_SP3; state <= S_PU_RD;
            end
            K_SP3: begin
              k_ord <= k_ord - 1'b1; state <= S_SPLIT;
            end
            K_TAKE: state <= S_TAKE;
            K_FPUSH: state <= S_MRD;
            K_M1: begin
              u_slot <= bud; u_ord <= cur_ord; kont <= K_M2; state <= S_RM_RD;
            end
            K_M2: begin
              u_slot <= (cur < bud) ? cur : bud; u_ord <= cur_ord + 1'b1;
              cur <= (cur < bud) ? cur : bud; cur_ord <= cur_ord + 1'b1;
              kont <= K_M3; state <= S_PU_RD;
            end
            K_M3: state <= S_MRD;
            default: state <= S_IDLE;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BBA_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy || state == S_AFIND || state == S_FRD)
  `BBA_ASSERT_IMP(a_cnt_used, clk, rst, block_count == '0, used_bytes == '0)
  `BBA_ASSERT_IMP(a_ok_off, clk, rst, done && status != ST_OK, granted_offset == '0)
endmodule

// ----- test/buddy_block_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb
// Drives allocate and free commands and tracks pool state in a shadow model.
// A queue of pending commands feeds the driver; most random frees target live offsets.
// Each result is compared field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int MIN_ORD = MIN_ORDER_D;
  localparam int MAX_ORD = MAX_ORDER_D;
  localparam int POOL    = POOL_BYTES_D;
  localparam int HDR     = HEADER_BYTES_D;
  localparam int SLOTS   = POOL >> MIN_ORD;
  localparam int NORD    = MAX_ORD - MIN_ORD + 1;
  localparam int NIL     = SLOTS;

  typedef struct {
    logic        func;
    logic [15:0] size;
    logic [15:0] uoff;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] granted;
    logic [16:0] used;
    logic [11:0] count;
    logic [16:0] free;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = FUNC_ALLOC;
  logic [15:0] request_size = '0;
  logic [15:0] user_offset = '0;
  logic        busy, done;
  logic [1:0]  status;
  logic [15:0] granted_offset;
  logic [16:0] used_bytes;
  logic [11:0] block_count;
  logic [16:0] free_bytes;

  buddy_block_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .request_size(request_size), .user_offset(user_offset),
    .done(done), .status(status), .granted_offset(granted_offset),
    .used_bytes(used_bytes), .block_count(block_count), .free_bytes(free_bytes)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow pool state
  bit          blk_free [SLOTS];
  int          blk_ord  [SLOTS];
  int          blk_next [SLOTS];
  int          blk_prev [SLOTS];
  int          head     [NORD];
  int          used_sum;
  int          live_cnt;

  cmd_t        cmd_q[$];
  result_t     exp_q[$];
  int          live_q[$];
  int          freed_q[$];
  int          errors = 0;
  int          gap = 0;
  bit          quiet = 1'b0;
  cmd_t        cur;

  function automatic void free_list_push(int ord, int s);
    int h;
    h = head[ord - MIN_ORD];
    blk_next[s] = h;
    blk_prev[s] = NIL;
    blk_ord[s]  = ord;
    blk_free[s] = 1'b1;
    if (h < SLOTS) blk_prev[h] = s;
    head[ord - MIN_ORD] = s;
  endfunction

  function automatic void free_list_unlink(int ord, int s);
    int p, n;
    p = blk_prev[s];
    n = blk_next[s];
    if (p < SLOTS) blk_next[p] = n;
    else head[ord - MIN_ORD] = n;
    if (n < SLOTS) blk_prev[n] = p;
    blk_next[s] = NIL;
    blk_prev[s] = NIL;
  endfunction

  function automatic void pool_reset();
    longint rem, off;
    int ord;
    rem = POOL;
    off = 0;
    ord = MAX_ORD;
    for (int i = 0; i < SLOTS; i++) begin
      blk_free[i] = 1'b0;
      blk_ord[i]  = 0;
      blk_next[i] = NIL;
      blk_prev[i] = NIL;
    end
    for (int i = 0; i < NORD; i++) head[i] = NIL;
    used_sum = 0;
    live_cnt = 0;
    while (rem >= (longint'(1) << MIN_ORD)) begin
      while ((longint'(1) << ord) > rem && ord > MIN_ORD) ord--;
      free_list_push(ord, int'(off >> MIN_ORD));
      off += longint'(1) << ord;
      rem -= longint'(1) << ord;
    end
  endfunction

  function automatic logic [1:0] pool_alloc(int req, output int grant);
    int need, ord, k, s;
    grant = 0;
    need = req + HDR;
    ord = MIN_ORD;
    if (req == 0) return ST_NOBLOCK;
    while ((1 << ord) < need && ord < MAX_ORD) ord++;
    if ((1 << ord) < need) return ST_NOBLOCK;
    k = ord;
    while (k <= MAX_ORD && head[k - MIN_ORD] >= SLOTS) k++;
    if (k > MAX_ORD) return ST_NOBLOCK;
    for (int j = k; j > ord; j--) begin
      s = head[j - MIN_ORD];
      free_list_unlink(j, s);
      free_list_push(j - 1, s);
      free_list_push(j - 1, s + (1 << (j - 1 - MIN_ORD)));
    end
    s = head[ord - MIN_ORD];
    free_list_unlink(ord, s);
    blk_free[s] = 1'b0;
    blk_ord[s]  = ord;
    live_cnt++;
    used_sum += (1 << ord) - HDR;
    grant = (s << MIN_ORD) + HDR;
    return ST_OK;
  endfunction

  function automatic logic [1:0] pool_release(int uoff);
    int boff, s, ord, b, m;
    if (uoff < HDR) return ST_BADPTR;
    boff = uoff - HDR;
    if ((boff & ((1 << MIN_ORD) - 1)) != 0 || (boff >> MIN_ORD) >= SLOTS) return ST_BADPTR;
    s = boff >> MIN_ORD;
    if (blk_free[s]) return ST_DOUBLE;
    ord = blk_ord[s];
    if (ord < MIN_ORD || ord > MAX_ORD) return ST_BADPTR;
    if ((boff & ((1 << ord) - 1)) != 0 || boff + (1 << ord) > POOL) return ST_BADPTR;
    live_cnt--;
    used_sum -= (1 << ord) - HDR;
    free_list_push(ord, s);
    while (ord < MAX_ORD) begin
      b = s ^ (1 << (ord - MIN_ORD));
      if (b >= SLOTS || !blk_free[b] || blk_ord[b] != ord) break;
      free_list_unlink(ord, s);
      free_list_unlink(ord, b);
      m = (s < b) ? s : b;
      free_list_push(ord + 1, m);
      s = m;
      ord++;
    end
    return ST_OK;
  endfunction

  function automatic void predict_command(cmd_t c);
    result_t r;
    int g;
    g = 0;
    if (c.func == FUNC_ALLOC) begin
      r.status = pool_alloc(int'(c.size), g);
      if (r.status == ST_OK) live_q.push_back(g);
    end else begin
      r.status = pool_release(int'(c.uoff));
    end
    r.granted = g[15:0];
    r.used    = used_sum[16:0];
    r.count   = live_cnt[11:0];
    r.free    = 17'(POOL - used_sum);
    exp_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_command(cur);
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur = cmd_q.pop_front();
          func <= cur.func;
          request_size <= cur.size;
          user_offset <= cur.uoff;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (granted_offset !== e.granted) begin
          $display("%0t: granted_offset exp %0d got %0d", $time, e.granted, granted_offset);
          errors++;
        end
        if (used_bytes !== e.used) begin
          $display("%0t: used_bytes exp %0d got %0d", $time, e.used, used_bytes);
          errors++;
        end
        if (block_count !== e.count) begin
          $display("%0t: block_count exp %0d got %0d", $time, e.count, block_count);
          errors++;
        end
        if (free_bytes !== e.free) begin
          $display("%0t: free_bytes exp %0d got %0d", $time, e.free, free_bytes);
          errors++;
        end
      end
    end
  end

  task automatic send(logic f, int sz, int off);
    cmd_t c;
    c.func = f;
    c.size = sz[15:0];
    c.uoff = off[15:0];
    while (cmd_q.size() > 2) @(posedge clk);
    cmd_q.push_back(c);
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || start || exp_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int r, idx, off, sz;
    pool_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: size edges, exhaustion, double free, bad pointers, split/merge
    send(FUNC_ALLOC, 0, 0);
    send(FUNC_ALLOC, 65513, 0);
    send(FUNC_ALLOC, 65535, 0);
    send(FUNC_ALLOC, 65512, 0);
    send(FUNC_ALLOC, 1, 0);
    send(FUNC_FREE, 0, 24);
    send(FUNC_FREE, 0, 24);
    send(FUNC_ALLOC, 8, 0);
    send(FUNC_ALLOC, 9, 0);
    send(FUNC_ALLOC, 8, 0);
    send(FUNC_FREE, 0, 0);
    send(FUNC_FREE, 0, 23);
    send(FUNC_FREE, 0, 25);
    send(FUNC_FREE, 0, 65535);
    send(FUNC_FREE, 0, 65528);
    send(FUNC_FREE, 0, 88);
    send(FUNC_FREE, 0, 56);
    send(FUNC_FREE, 0, 24);
    send(FUNC_FREE, 0, 152);
    send(FUNC_FREE, 0, 56);
    drain();
    live_q.delete();

    for (int n = 0; n < 1600; n++) begin
      if (n == 1450) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (live_q.size() > 48) r = r / 2 + 50;
      if (r < 45) begin
        r = $urandom_range(0, 99);
        if (r < 4) sz = 0;
        else if (r < 9) sz = $urandom_range(0, 65535);
        else if (r < 13) sz = $urandom_range(65500, 65535);
        else sz = $urandom_range(1, 1 << $urandom_range(3, 12));
        send(FUNC_ALLOC, sz, $urandom_range(0, 65535));
      end else if (r < 88 && live_q.size() > 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        off = live_q[idx];
        live_q.delete(idx);
        freed_q.push_back(off);
        if (freed_q.size() > 64) void'(freed_q.pop_front());
        send(FUNC_FREE, $urandom_range(0, 65535), off);
      end else if (r < 94 && freed_q.size() > 0) begin
        send(FUNC_FREE, 0, freed_q[$urandom_range(0, freed_q.size() - 1)]);
      end else if (r < 97) begin
        send(FUNC_FREE, 0, ($urandom_range(0, SLOTS - 1) << MIN_ORD) + HDR);
      end else begin
        send(FUNC_FREE, 0, $urandom_range(0, 65535));
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
